FILE: hdl/maec_pkg.sv
package maec_pkg;

  localparam int PitchMax = 23040;
  localparam int unsigned AtanDepth = 24;

  typedef enum logic [3:0] {
    EV_LIFTED      = 4'd0,
    EV_DOUBLE_TAP  = 4'd1,
    EV_FRONT_HIT   = 4'd2,
    EV_REAR_HIT    = 4'd3,
    EV_KICK_LEFT   = 4'd4,
    EV_KICK_RIGHT  = 4'd5,
    EV_CLIMBING    = 4'd6,
    EV_DESCENDING  = 4'd7,
    EV_VERY_CLOSE  = 4'd8,
    EV_OBSTACLE0   = 4'd9
  } event_e;

  typedef enum logic [2:0] {
    REG_TILT_PERIOD = 3'd0,
    REG_TILT_THRESH = 3'd1,
    REG_FILT_WEIGHT = 3'd2,
    REG_TAP_Z       = 3'd3,
    REG_TAP_X       = 3'd4,
    REG_RANGE_HYST  = 3'd5,
    REG_NEAR_LIMIT  = 3'd6,
    REG_OBST_LIMIT  = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_FILT_MUL,
    ST_FILT_ADD,
    ST_DONE
  } back_state_e;

  // work handed from the front to the back part
  typedef struct packed {
    logic        tilt;      // pitch update needed
    logic        has_ev;    // event from the front
    logic [3:0]  ev;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } job_t;

  function automatic logic [31:0] atan_deg_q16(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd2949120;  5'd1: r = 32'd1740967;  5'd2: r = 32'd919879;
      5'd3: r = 32'd466945;   5'd4: r = 32'd234379;   5'd5: r = 32'd117265;
      5'd6: r = 32'd58666;    5'd7: r = 32'd29335;    5'd8: r = 32'd14668;
      5'd9: r = 32'd7334;     5'd10: r = 32'd3667;    5'd11: r = 32'd1833;
      5'd12: r = 32'd917;     5'd13: r = 32'd458;     5'd14: r = 32'd229;
      5'd15: r = 32'd115;     5'd16: r = 32'd57;      5'd17: r = 32'd29;
      5'd18: r = 32'd14;      5'd19: r = 32'd7;       5'd20: r = 32'd4;
      5'd21: r = 32'd2;       5'd22: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/maec_front.sv
module maec_front #(
  parameter int unsigned RANGE_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        cmd_i,
  input  logic [15:0] accel_x_i,
  input  logic [15:0] accel_y_i,
  input  logic [15:0] accel_z_i,
  input  logic [7:0]  int_source_i,
  input  logic [31:0] now_tick_i,
  input  logic [1:0]  range_channel_i,
  input  logic [12:0] distance_mm_i,
  input  logic [15:0] tilt_period_i,
  input  logic [14:0] tap_z_i,
  input  logic [14:0] tap_x_i,
  input  logic [12:0] hyst_i,
  input  logic [12:0] near_i,
  input  logic [12:0] obst_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output maec_pkg::job_t job_o
);

  localparam int unsigned ChW = (RANGE_CHANNELS > 1) ? $clog2(RANGE_CHANNELS) : 1;

  logic [31:0] last_tick_q, last_tick_d;
  logic [15:0] last_dist_q [RANGE_CHANNELS];
  logic        take;
  logic signed [16:0] ax, az, zt, xt;
  logic [3:0]  tap_ev;
  logic        tap_has;
  logic        tilt;
  logic [31:0] elapsed;
  logic        ch_ok;
  logic [ChW-1:0] ch;
  logic [15:0] last, dist16, diff;
  logic        counts;
  logic [3:0]  rng_ev;
  logic        rng_has;
  maec_pkg::job_t job;

  assign ready_o = job_ready_i;
  assign take    = valid_i && job_ready_i;
  assign ax = {accel_x_i[15], accel_x_i};
  assign az = {accel_z_i[15], accel_z_i};
  assign zt = {2'b00, tap_z_i};
  assign xt = {2'b00, tap_x_i};
  assign elapsed = now_tick_i - last_tick_q;
  assign tilt = elapsed >= {16'd0, tilt_period_i};
  assign ch_ok = {30'd0, range_channel_i} < RANGE_CHANNELS;
  assign ch = ChW'(range_channel_i);
  assign last = ch_ok ? last_dist_q[ch] : 16'hFFFF;
  assign dist16 = {3'd0, distance_mm_i};
  assign diff = (dist16 > last) ? dist16 - last : last - dist16;
  assign counts = ch_ok && (diff > {3'd0, hyst_i});

  always_comb begin
    tap_has = 1'b1;
    tap_ev  = maec_pkg::EV_LIFTED;
    if (int_source_i[4]) tap_ev = maec_pkg::EV_LIFTED;
    else if (int_source_i[5]) tap_ev = maec_pkg::EV_DOUBLE_TAP;
    else if (int_source_i[6] && az > zt) tap_ev = maec_pkg::EV_FRONT_HIT;
    else if (int_source_i[6] && az < -zt) tap_ev = maec_pkg::EV_REAR_HIT;
    else if (int_source_i[6] && ax > xt) tap_ev = maec_pkg::EV_KICK_LEFT;
    else if (int_source_i[6] && ax < -xt) tap_ev = maec_pkg::EV_KICK_RIGHT;
    else tap_has = 1'b0;
    rng_has = 1'b0;
    rng_ev  = maec_pkg::EV_VERY_CLOSE;
    if (counts && distance_mm_i < near_i) rng_has = 1'b1;
    else if (counts && distance_mm_i < obst_i) begin
      rng_has = 1'b1;
      rng_ev  = 4'(maec_pkg::EV_OBSTACLE0) + {2'd0, range_channel_i};
    end
    job.ax = accel_x_i;
    job.ay = accel_y_i;
    job.az = accel_z_i;
    if (!cmd_i) begin
      job.tilt = tilt; job.has_ev = tap_has; job.ev = tap_ev;
    end else begin
      job.tilt = 1'b0; job.has_ev = rng_has; job.ev = rng_ev;
    end
  end

  always_comb begin
    last_tick_d = last_tick_q;
    if (take && !cmd_i && tilt) last_tick_d = now_tick_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q <= '0;
      for (int i = 0; i < RANGE_CHANNELS; i++) last_dist_q[i] <= 16'hFFFF;
    end else begin
      last_tick_q <= last_tick_d;
      if (take && cmd_i && counts) last_dist_q[ch] <= dist16;
    end
  end

  assign job_valid_o = valid_i && (job.has_ev || job.tilt);
  assign job_o = job;

endmodule

FILE: hdl/maec_queue.sv
module maec_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  maec_pkg::job_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output maec_pkg::job_t out_o
);

  maec_pkg::job_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, wp_d, rp_q, rp_d;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_o = mem_q[rp_q];

  always_comb begin
    wp_d = push ? ~wp_q : wp_q;
    rp_d = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; wp_q <= wp_d; rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("full queue lost entry");
  a_empty_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 && !push |=> cnt_q == 2'd0) else $error("empty queue gained entry");
`endif

endmodule

FILE: hdl/maec_back.sv
module maec_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  maec_pkg::job_t job_i,
  input  logic [14:0] tilt_thresh_i,
  input  logic [15:0] weight_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [3:0]  event_code_o
);

  localparam int unsigned CW = 48;

  maec_pkg::back_state_e st_q, st_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] rem_q, rem_d, res_q, res_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, ang_q, ang_d;
  logic signed [16:0] f_q, f_d;
  logic signed [34:0] prod_q, prod_d;
  logic        has_q, has_d;
  logic [3:0]  ev_q, ev_d;
  logic        zero_q, zero_d;
  logic signed [15:0] ax_q, ax_d;
  logic        out_v_q, out_v_d;
  logic [3:0]  out_ev_q, out_ev_d;
  logic [31:0] sq_sum, bit_v, trial;
  logic signed [CW-1:0] dx, dy, pr;
  logic signed [17:0] p_clamp, pdiff;
  logic signed [CW-1:0] f_new;
  logic signed [17:0] th;
  logic [31:0] ysq, zsq;

  assign ysq = 32'($signed(job_i.ay) * $signed(job_i.ay));
  assign zsq = 32'($signed(job_i.az) * $signed(job_i.az));
  assign sq_sum = ysq + zsq;
  assign bit_v = 32'h4000_0000 >> {step_q, 1'b0};
  assign trial = res_q + bit_v;
  assign dx = cy_q >>> step_q;
  assign dy = cx_q >>> step_q;
  assign pr = (ang_q + CW'(128)) >>> 8;
  assign th = {3'd0, tilt_thresh_i};

  always_comb begin
    if (zero_q) p_clamp = '0;
    else if (pr > CW'(maec_pkg::PitchMax)) p_clamp = 18'(maec_pkg::PitchMax);
    else if (pr < -CW'(maec_pkg::PitchMax)) p_clamp = -18'(maec_pkg::PitchMax);
    else p_clamp = 18'(pr);
  end
  assign pdiff = p_clamp - 18'(f_q);
  assign f_new = CW'(f_q) + ((CW'(prod_q) + CW'(32768)) >>> 16);

  // a waiting result is held in the output register, the done state waits for it
  assign job_ready_o = (st_q == maec_pkg::ST_IDLE);
  assign valid_o = out_v_q;
  assign event_code_o = out_ev_q;

  always_comb begin
    st_d = st_q; step_d = step_q; rem_d = rem_q; res_d = res_q;
    cx_d = cx_q; cy_d = cy_q; ang_d = ang_q; f_d = f_q; prod_d = prod_q;
    has_d = has_q; ev_d = ev_q; zero_d = zero_q; ax_d = ax_q;
    out_v_d = out_v_q && !ready_i; out_ev_d = out_ev_q;
    case (st_q)
      maec_pkg::ST_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          has_d = job_i.has_ev; ev_d = job_i.ev;
          ax_d = job_i.ax; rem_d = sq_sum; res_d = '0; step_d = '0;
          st_d = job_i.tilt ? maec_pkg::ST_SQRT : maec_pkg::ST_DONE;
        end
      end
      maec_pkg::ST_SQRT: begin
        // one result bit per cycle
        if (rem_q >= trial) begin
          rem_d = rem_q - trial; res_d = (res_q >> 1) + bit_v;
        end else begin
          res_d = res_q >> 1;
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          step_d = '0;
          cx_d = CW'(res_d) <<< 8;
          cy_d = CW'(ax_q) <<< 8;
          ang_d = '0;
          zero_d = (res_d == 32'd0) && (ax_q == 16'sd0);
          st_d = maec_pkg::ST_CORDIC;
        end
      end
      maec_pkg::ST_CORDIC: begin
        if (cy_q > 0) begin
          cx_d = cx_q + dx; cy_d = cy_q - dy;
          ang_d = ang_q + CW'(maec_pkg::atan_deg_q16(step_q));
        end else begin
          cx_d = cx_q - dx; cy_d = cy_q + dy;
          ang_d = ang_q - CW'(maec_pkg::atan_deg_q16(step_q));
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'(CORDIC_STEPS - 1)) st_d = maec_pkg::ST_FILT_MUL;
      end
      maec_pkg::ST_FILT_MUL: begin
        prod_d = 35'(pdiff * $signed({1'b0, weight_i}));
        st_d = maec_pkg::ST_FILT_ADD;
      end
      maec_pkg::ST_FILT_ADD: begin
        f_d = 17'(f_new);
        if (f_new > CW'(th)) begin
          has_d = 1'b1; ev_d = maec_pkg::EV_CLIMBING;
        end else if (f_new < -CW'(th)) begin
          has_d = 1'b1; ev_d = maec_pkg::EV_DESCENDING;
        end
        st_d = maec_pkg::ST_DONE;
      end
      maec_pkg::ST_DONE: begin
        if (!out_v_d) begin
          out_v_d = has_q; out_ev_d = ev_q;
          st_d = maec_pkg::ST_IDLE;
        end
      end
      default: st_d = maec_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= maec_pkg::ST_IDLE; f_q <= '0; out_v_q <= 1'b0; step_q <= '0;
    end else begin
      st_q <= st_d; f_q <= f_d; out_v_q <= out_v_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; cx_q <= cx_d; cy_q <= cy_d; ang_q <= ang_d;
    prod_q <= prod_d; has_q <= has_d; ev_q <= ev_d;
    zero_q <= zero_d; ax_q <= ax_d; out_ev_q <= out_ev_d;
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !ready_i |=> out_v_q && $stable(out_ev_q)) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != maec_pkg::ST_IDLE |-> !job_ready_o) else $error("job taken while busy");
  a_filter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_q <= 17'sd23040 && f_q >= -17'sd23040) else $error("filter out of range");
`endif

endmodule

FILE: hdl/motion_and_range_event_classifier.sv
// channel | direction | handshake        | payload
// input   | in        | valid_i/ready_o  | cmd, accel xyz, int_source, now_tick, channel, dist
// result  | out       | valid_o/ready_i  | event_code
// config  | in        | cfg_we_i         | cfg_index_i, cfg_data_i
// a range reading or tap-only sample: queued, then through the done state to the output register
// a sample with pitch update: the result waits on the sqrt iteration (16 steps)
//   and the iterated cordic stage, one step a cycle
// the front accepts while the back works, until the two-entry queue fills
// reset: asynchronous active low, registers to defaults, range history to 65535
module motion_and_range_event_classifier #(
  parameter int unsigned RANGE_CHANNELS = 4,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        cmd_i,
  input  logic [15:0] accel_x_i,
  input  logic [15:0] accel_y_i,
  input  logic [15:0] accel_z_i,
  input  logic [7:0]  int_source_i,
  input  logic [31:0] now_tick_i,
  input  logic [1:0]  range_channel_i,
  input  logic [12:0] distance_mm_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [3:0]  event_code_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic [15:0] tilt_period_q;
  logic [14:0] tilt_thresh_q;
  logic [15:0] weight_q;
  logic [14:0] tap_z_q, tap_x_q;
  logic [12:0] hyst_q, near_q, obst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_period_q <= 16'd25;
      tilt_thresh_q <= 15'd5120;
      weight_q      <= 16'd9830;
      tap_z_q       <= 15'd1300;
      tap_x_q       <= 15'd1400;
      hyst_q        <= 13'd20;
      near_q        <= 13'd80;
      obst_q        <= 13'd150;
    end else if (cfg_we_i) begin
      case (maec_pkg::reg_e'(cfg_index_i))
        maec_pkg::REG_TILT_PERIOD: tilt_period_q <= cfg_data_i;
        maec_pkg::REG_TILT_THRESH: tilt_thresh_q <= cfg_data_i[14:0];
        maec_pkg::REG_FILT_WEIGHT: weight_q <= cfg_data_i;
        maec_pkg::REG_TAP_Z:       tap_z_q <= cfg_data_i[14:0];
        maec_pkg::REG_TAP_X:       tap_x_q <= cfg_data_i[14:0];
        maec_pkg::REG_RANGE_HYST:  hyst_q <= cfg_data_i[12:0];
        maec_pkg::REG_NEAR_LIMIT:  near_q <= cfg_data_i[12:0];
        maec_pkg::REG_OBST_LIMIT:  obst_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // front classifies; items with no event and no pitch work are dropped there
  logic job_v, job_r, q_v, q_r;
  maec_pkg::job_t job, q_job;
  logic front_ready;

  maec_front #(.RANGE_CHANNELS(RANGE_CHANNELS)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o(front_ready),
    .cmd_i, .accel_x_i, .accel_y_i, .accel_z_i, .int_source_i, .now_tick_i,
    .range_channel_i, .distance_mm_i,
    .tilt_period_i(tilt_period_q), .tap_z_i(tap_z_q), .tap_x_i(tap_x_q),
    .hyst_i(hyst_q), .near_i(near_q), .obst_i(obst_q),
    .job_valid_o(job_v), .job_ready_i(job_r), .job_o(job)
  );
  assign ready_o = front_ready;

  // two-entry decoupling queue
  maec_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(job_v), .in_ready_o(job_r), .in_i(job),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(q_job)
  );

  // back: sqrt, cordic, filter, result register
  maec_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(q_v), .job_ready_o(q_r), .job_i(q_job),
    .tilt_thresh_i(tilt_thresh_q), .weight_i(weight_q),
    .valid_o, .ready_i, .event_code_o
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // one input transaction
  typedef struct {
    logic        cmd;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [7:0]  src;
    logic [31:0] tick;
    logic [1:0]  ch;
    logic [12:0] dist_mm;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic        cmd_i = 1'b0;
  logic [15:0] accel_x_i = '0;
  logic [15:0] accel_y_i = '0;
  logic [15:0] accel_z_i = '0;
  logic [7:0]  int_source_i = '0;
  logic [31:0] now_tick_i = '0;
  logic [1:0]  range_channel_i = '0;
  logic [12:0] distance_mm_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [3:0]  event_code_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  motion_and_range_event_classifier DUT (.*);

  always #4 clk_i = ~clk_i;

  // testbench-side copy of the classifier state and registers
  longint     m_period, m_thresh, m_weight, m_tapz, m_tapx, m_hyst, m_near, m_obst;
  longint     m_filt;
  logic [31:0] m_last_tick;
  longint     m_last_dist[4];

  sample_t    pending_q[$];
  maec_pkg::event_e expected_events_q[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         mismatches = 0;
  int         events_seen = 0;
  int         items_sent = 0;
  longint     tick_now = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;  // arithmetic shift on signed longint is floor
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117265, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // pitch in Q7.8 degrees from a vectoring rotation
  function automatic longint pitch_of(longint x, longint y, longint z);
    longint r, cx, cy, ang, dx, dy, p;
    logic [31:0] sum;
    sum = 32'(y * y) + 32'(z * z);
    r = int_sqrt(longint'(sum));
    if (r == 0 && x == 0) return 0;
    cx = r * 256;
    cy = x * 256;
    ang = 0;
    for (int i = 0; i < 16; i++) begin
      dx = fshift(cy, i);
      dy = fshift(cx, i);
      if (cy > 0) begin
        cx += dx; cy -= dy; ang += atan_entry(i);
      end else begin
        cx -= dx; cy += dy; ang -= atan_entry(i);
      end
    end
    p = fshift(ang + 128, 8);
    if (p > maec_pkg::PitchMax) p = maec_pkg::PitchMax;
    if (p < -longint'(maec_pkg::PitchMax)) p = -longint'(maec_pkg::PitchMax);
    return p;
  endfunction

  task automatic classify(input sample_t s);
    longint ax, ay, az, p, d, diff;
    int ev;
    ev = -1;
    if (!s.cmd) begin
      ax = longint'($signed(s.ax));
      ay = longint'($signed(s.ay));
      az = longint'($signed(s.az));
      if (s.src[4]) ev = maec_pkg::EV_LIFTED;
      else if (s.src[5]) ev = maec_pkg::EV_DOUBLE_TAP;
      else if (s.src[6]) begin
        if (az > m_tapz) ev = maec_pkg::EV_FRONT_HIT;
        else if (az < -m_tapz) ev = maec_pkg::EV_REAR_HIT;
        else if (ax > m_tapx) ev = maec_pkg::EV_KICK_LEFT;
        else if (ax < -m_tapx) ev = maec_pkg::EV_KICK_RIGHT;
      end
      if (longint'(32'(s.tick - m_last_tick)) >= m_period) begin
        p = pitch_of(ax, ay, az);
        m_filt += fshift((p - m_filt) * m_weight + 32768, 16);
        if (m_filt > m_thresh) ev = maec_pkg::EV_CLIMBING;
        else if (m_filt < -m_thresh) ev = maec_pkg::EV_DESCENDING;
        m_last_tick = s.tick;
      end
    end else begin
      d = s.dist_mm;
      diff = d > m_last_dist[s.ch] ? d - m_last_dist[s.ch] : m_last_dist[s.ch] - d;
      if (diff > m_hyst) begin
        m_last_dist[s.ch] = d;
        if (d < m_near) ev = maec_pkg::EV_VERY_CLOSE;
        else if (d < m_obst) ev = maec_pkg::EV_OBSTACLE0 + s.ch;
      end
    end
    if (ev >= 0) expected_events_q.push_back(maec_pkg::event_e'(ev));
  endtask

  // register write, only called while idle
  task automatic write_reg(input maec_pkg::reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      maec_pkg::REG_TILT_PERIOD: m_period = val;
      maec_pkg::REG_TILT_THRESH: m_thresh = val[14:0];
      maec_pkg::REG_FILT_WEIGHT: m_weight = val;
      maec_pkg::REG_TAP_Z:       m_tapz = val[14:0];
      maec_pkg::REG_TAP_X:       m_tapx = val[14:0];
      maec_pkg::REG_RANGE_HYST:  m_hyst = val[12:0];
      maec_pkg::REG_NEAR_LIMIT:  m_near = val[12:0];
      default:                   m_obst = val[12:0];
    endcase
  endtask

  // driver: valid stays up with the payload until the transaction is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        classify(pending_q.pop_front());
        items_sent++;
      end
      if ((!valid_i || ready_o)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          valid_i <= 1'b1;
          cmd_i <= pending_q[0].cmd;
          accel_x_i <= pending_q[0].ax;
          accel_y_i <= pending_q[0].ay;
          accel_z_i <= pending_q[0].az;
          int_source_i <= pending_q[0].src;
          now_tick_i <= pending_q[0].tick;
          range_channel_i <= pending_q[0].ch;
          distance_mm_i <= pending_q[0].dist_mm;
        end else begin
          valid_i <= 1'b0;
        end
      end
      ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // pending_q[0] is the driven item while valid is high; the pop above keeps that true
  // because a new item is loaded only after the previous one was taken

  // monitor: compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      events_seen++;
      if (expected_events_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %0d", event_code_o);
      end else begin
        if (event_code_o !== expected_events_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: expected %0d got %0d", expected_events_q[0], event_code_o);
        end
        void'(expected_events_q.pop_front());
      end
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    s.cmd = 1'($urandom_range(1));
    s.ax = 16'($urandom);
    s.ay = 16'($urandom);
    s.az = 16'($urandom);
    // mostly one flag, sometimes none or random bytes
    case ($urandom_range(5))
      0: s.src = 8'h10;
      1: s.src = 8'h20;
      2, 3: s.src = 8'h40;
      4: s.src = 8'($urandom);
      default: s.src = 8'h00;
    endcase
    if ($urandom_range(2) == 0) begin
      // small tap-sized values to land around the thresholds
      s.ax = 16'($signed($urandom_range(4000)) - 2000);
      s.az = 16'($signed($urandom_range(4000)) - 2000);
    end
    tick_now += $urandom_range(40);
    if ($urandom_range(30) == 0) tick_now += $urandom;
    s.tick = 32'(tick_now);
    s.ch = 2'($urandom);
    s.dist_mm = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(300));
    return s;
  endfunction

  function automatic sample_t mk_accel(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                       logic [7:0] src, logic [31:0] tick);
    sample_t s;
    s = '{cmd: 1'b0, ax: x, ay: y, az: z, src: src, tick: tick, ch: 2'd0, dist_mm: 13'd0};
    return s;
  endfunction

  function automatic sample_t mk_range(logic [1:0] ch, logic [12:0] dist_mm);
    sample_t s;
    s = '{cmd: 1'b1, ax: 16'hFFFF, ay: 16'hFFFF, az: 16'hFFFF, src: 8'hFF,
          tick: 32'hFFFF_FFFF, ch: ch, dist_mm: dist_mm};
    return s;
  endfunction

  // wait for every expectation, then let the pitch pipeline drain
  task automatic drain();
    wait (pending_q.size() == 0 && !valid_i);
    wait (expected_events_q.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    repeat (n) pending_q.push_back(rand_sample());
    drain();
  endtask

  initial begin
    m_period = 25; m_thresh = 5120; m_weight = 9830; m_tapz = 1300; m_tapx = 1400;
    m_hyst = 20; m_near = 80; m_obst = 150;
    m_filt = 0; m_last_tick = '0;
    foreach (m_last_dist[i]) m_last_dist[i] = 65535;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: flag priority, tap sorting, zero vector, extremes
    pending_q.push_back(mk_accel(16'h0000, 16'h0000, 16'h0000, 8'h70, 32'd1));
    pending_q.push_back(mk_accel(16'h0000, 16'h0000, 16'h0000, 8'h60, 32'd2));
    pending_q.push_back(mk_accel(16'h0000, 16'h0000, 16'd1301, 8'h40, 32'd3));
    pending_q.push_back(mk_accel(16'h0000, 16'h0000, -16'sd1301, 8'h40, 32'd4));
    pending_q.push_back(mk_accel(16'd1401, 16'h0000, 16'd1300, 8'h40, 32'd5));
    pending_q.push_back(mk_accel(-16'sd1401, 16'h0000, 16'h0000, 8'h40, 32'd6));
    pending_q.push_back(mk_accel(16'd1400, 16'h0000, -16'sd1300, 8'h40, 32'd7));
    pending_q.push_back(mk_accel(16'h0000, 16'h0000, 16'h0000, 8'h8F, 32'd30));
    pending_q.push_back(mk_accel(16'h7FFF, 16'h8000, 16'h8000, 8'h00, 32'd60));
    pending_q.push_back(mk_accel(16'h7FFF, 16'h0000, 16'h0000, 8'h40, 32'd90));
    pending_q.push_back(mk_accel(16'h8000, 16'h7FFF, 16'h7FFF, 8'h20, 32'd120));
    pending_q.push_back(mk_accel(16'h8000, 16'h0000, 16'h0001, 8'h00, 32'hFFFF_FFFF));
    pending_q.push_back(mk_range(2'd0, 13'd0));
    pending_q.push_back(mk_range(2'd0, 13'd10));
    pending_q.push_back(mk_range(2'd1, 13'd100));
    pending_q.push_back(mk_range(2'd2, 13'd149));
    pending_q.push_back(mk_range(2'd3, 13'd120));
    pending_q.push_back(mk_range(2'd3, 13'd8191));
    pending_q.push_back(mk_range(2'd1, 13'd80));
    pending_q.push_back(mk_range(2'd2, 13'd150));
    tick_now = 200;
    drain();

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 19; recv_idle_pct = 87;
    random_phase(150);

    // period zero and extremes of every register
    write_reg(maec_pkg::REG_TILT_PERIOD, 16'd0);
    write_reg(maec_pkg::REG_TILT_THRESH, 16'd0);
    write_reg(maec_pkg::REG_FILT_WEIGHT, 16'hFFFF);
    write_reg(maec_pkg::REG_TAP_Z, 16'd0);
    write_reg(maec_pkg::REG_TAP_X, 16'hFFFF);
    write_reg(maec_pkg::REG_RANGE_HYST, 16'd0);
    write_reg(maec_pkg::REG_NEAR_LIMIT, 16'hFFFF);
    write_reg(maec_pkg::REG_OBST_LIMIT, 16'd0);
    send_idle_pct = 87; recv_idle_pct = 19;
    random_phase(150);

    write_reg(maec_pkg::REG_TILT_PERIOD, 16'hFFFF);
    write_reg(maec_pkg::REG_TILT_THRESH, 16'd23040);
    write_reg(maec_pkg::REG_FILT_WEIGHT, 16'd0);
    write_reg(maec_pkg::REG_TAP_Z, 16'd32767);
    write_reg(maec_pkg::REG_TAP_X, 16'd0);
    write_reg(maec_pkg::REG_RANGE_HYST, 16'd8191);
    write_reg(maec_pkg::REG_NEAR_LIMIT, 16'd0);
    write_reg(maec_pkg::REG_OBST_LIMIT, 16'd8191);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(60);

    // mid settings so that tilt events show up often
    write_reg(maec_pkg::REG_TILT_PERIOD, 16'd10);
    write_reg(maec_pkg::REG_TILT_THRESH, 16'd1500);
    write_reg(maec_pkg::REG_FILT_WEIGHT, 16'd30000);
    write_reg(maec_pkg::REG_TAP_Z, 16'd900);
    write_reg(maec_pkg::REG_TAP_X, 16'd700);
    write_reg(maec_pkg::REG_RANGE_HYST, 16'd5);
    write_reg(maec_pkg::REG_NEAR_LIMIT, 16'd60);
    write_reg(maec_pkg::REG_OBST_LIMIT, 16'd200);
    random_phase(200);

    $display("sent %0d transactions, checked %0d events across four register settings",
             items_sent, events_seen);
    if (mismatches == 0 && expected_events_q.size() == 0) begin
      $display("PASS motion_and_range_event_classifier");
    end else begin
      $display("FAIL motion_and_range_event_classifier");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAIL motion_and_range_event_classifier");
    $finish;
  end

endmodule
